>>> src/spg_pkg.sv
package spg_pkg;

  localparam int MASK_AXES = 3;

  localparam logic [31:0] ORIGIN_POS  = 32'd5000;
  localparam logic [15:0] SPEED_RESET = 16'd10;

  localparam logic [2:0] CFG_UPPER_BASE = 3'd0;
  localparam logic [2:0] CFG_LOWER_BASE = 3'd3;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_ABSOLUTE = 3'd1,
    MODE_RELATIVE = 3'd2,
    MODE_SPEED    = 3'd3,
    MODE_ORIGIN   = 3'd4,
    MODE_ESTOP    = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic        sel;
    logic [31:0] value;
    logic [15:0] speed;
  } axis_cmd_t;

  typedef struct packed {
    logic        step;
    logic        dir;
    logic        done;
    logic        below;
    logic        above;
    logic        clamp_low;
    logic        clamp_high;
    logic [31:0] position;
    logic [31:0] target;
    logic [15:0] speed;
  } axis_stat_t;

endpackage

>>> src/spg_if.sv
interface spg_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [1:0]         axis;
  logic signed [32:0] move_value;
  logic [15:0]        speed_value;

  modport source (output valid, mode, axis, move_value, speed_value, input ready);
  modport sink (input valid, mode, axis, move_value, speed_value, output ready);
endinterface

interface spg_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  step_pins;
  logic [2:0]  dir_pins;
  logic [2:0]  done_mask;
  logic [2:0]  below_limit_mask;
  logic [2:0]  above_limit_mask;
  logic [2:0]  clamped_low_mask;
  logic [2:0]  clamped_high_mask;
  logic [31:0] axis_position_out;
  logic [31:0] axis_target_out;
  logic [15:0] axis_speed_out;

  modport source (output valid, step_pins, dir_pins, done_mask, below_limit_mask,
                  above_limit_mask, clamped_low_mask, clamped_high_mask,
                  axis_position_out, axis_target_out, axis_speed_out,
                  input ready);
  modport sink (input valid, step_pins, dir_pins, done_mask, below_limit_mask,
                above_limit_mask, clamped_low_mask, clamped_high_mask,
                axis_position_out, axis_target_out, axis_speed_out,
                output ready);
endinterface

>>> src/spg_axis.sv
module spg_axis
  import spg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  axis_cmd_t   cmd,
  input  logic [31:0] upper,
  input  logic [31:0] lower,
  output axis_stat_t  stat
);

  logic [31:0] position, position_next;
  logic [31:0] target, target_next;
  logic [15:0] half_period, half_period_next;
  logic [16:0] tick_count, tick_count_next;
  logic        step_level, step_level_next;
  logic        dir_level, dir_level_next;
  logic        done_flag, done_flag_next;

  logic        below, above, clamp_low, clamp_high;
  logic [31:0] target_clamped;
  logic        dir_tick;

  always_comb begin
    below          = position < lower;
    above          = !below && (position > upper);
    clamp_low      = target < lower;
    clamp_high     = !clamp_low && (target > upper);
    target_clamped = clamp_low ? lower : (clamp_high ? upper : target);
    dir_tick       = position > target_clamped;
  end

  always_comb begin
    position_next    = position;
    target_next      = target;
    half_period_next = half_period;
    tick_count_next  = tick_count;
    step_level_next  = step_level;
    dir_level_next   = dir_level;
    done_flag_next   = done_flag;
    stat.below       = 1'b0;
    stat.above       = 1'b0;
    stat.clamp_low   = 1'b0;
    stat.clamp_high  = 1'b0;
    unique case (cmd.mode)
      MODE_TICK: begin
        stat.below      = below;
        stat.above      = above;
        stat.clamp_low  = clamp_low;
        stat.clamp_high = clamp_high;
        target_next     = target_clamped;
        dir_level_next  = dir_tick;
        if (half_period != 16'd0) begin
          if (position != target_clamped) begin
            done_flag_next = 1'b0;
            if (tick_count < {1'b0, half_period}) begin
              step_level_next = 1'b1;
              tick_count_next = tick_count + 17'd1;
            end else if (tick_count < {half_period, 1'b0}) begin
              step_level_next = 1'b0;
              tick_count_next = tick_count + 17'd1;
            end else begin
              tick_count_next = 17'd1;
              position_next   = dir_tick ? position - 32'd1 : position + 32'd1;
            end
          end else begin
            done_flag_next = 1'b1;
          end
        end
      end
      MODE_ABSOLUTE: begin
        if (cmd.sel) begin
          target_next = cmd.value;
        end
      end
      MODE_RELATIVE: begin
        if (cmd.sel) begin
          target_next = position + cmd.value;
        end
      end
      MODE_SPEED: begin
        if (cmd.sel) begin
          half_period_next = cmd.speed;
        end
      end
      MODE_ORIGIN: begin
        if (cmd.sel) begin
          position_next = ORIGIN_POS;
          target_next   = ORIGIN_POS;
        end
      end
      MODE_ESTOP: begin
        half_period_next = 16'd0;
        target_next      = position;
      end
      default: begin
      end
    endcase
    stat.step     = step_level_next;
    stat.dir      = dir_level_next;
    stat.done     = done_flag_next;
    stat.position = position_next;
    stat.target   = target_next;
    stat.speed    = half_period_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= ORIGIN_POS;
      target      <= ORIGIN_POS;
      half_period <= SPEED_RESET;
      tick_count  <= 17'd0;
      step_level  <= 1'b1;
      dir_level   <= 1'b1;
      done_flag   <= 1'b0;
    end else if (en) begin
      position    <= position_next;
      target      <= target_next;
      half_period <= half_period_next;
      tick_count  <= tick_count_next;
      step_level  <= step_level_next;
      dir_level   <= dir_level_next;
      done_flag   <= done_flag_next;
    end
  end

endmodule

>>> src/multi_axis_step_pulse_generator.sv
// Channel   Direction  Content
// items     in         mode, axis, move_value, speed_value
// results   out        pins, done and limit masks, addressed axis state
// cfg_*     in         limit register writes, index 0..5
//
// Each request is taken into an input register and finished once the result is
// free or taken, when the axis state and result register are written together.
// One request is accepted in every cycle while the result is not stalled.
// A stalled result holds the input register; requests are still taken while
// the input register is empty. Reset is synchronous.
module multi_axis_step_pulse_generator
  import spg_pkg::*;
#(
  parameter int AXES = 3
) (
  input  logic               clk,
  input  logic               rst,
  spg_item_if.sink           items,
  spg_result_if.source       results,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic        in_valid;
  mode_t       in_mode;
  logic [1:0]  in_axis;
  logic [31:0] in_move;
  logic [15:0] in_speed;
  logic        fire;

  logic [31:0] upper_limit [AXES];
  logic [31:0] lower_limit [AXES];
  logic [AXES-1:0] sel;
  axis_stat_t  stat [AXES];

  logic [MASK_AXES-1:0] step_m, dir_m, done_m, below_m, above_m, clo_m, chi_m;
  logic [31:0] pos_sel, tgt_sel;
  logic [15:0] spd_sel;

  assign fire        = in_valid && (!results.valid || results.ready);
  assign items.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
    if (items.ready && items.valid) begin
      in_mode  <= mode_t'(items.mode);
      in_axis  <= items.axis;
      in_move  <= items.move_value[31:0];
      in_speed <= items.speed_value;
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    axis_cmd_t cmd;

    assign sel[i]     = ({2'b00, in_axis} == 4'(i));
    assign cmd.mode   = in_mode;
    assign cmd.sel    = sel[i];
    assign cmd.value  = in_move;
    assign cmd.speed  = in_speed;

    always_ff @(posedge clk) begin
      if (rst) begin
        upper_limit[i] <= 32'hFFFF_FFFF;
        lower_limit[i] <= 32'd0;
      end else if (cfg_write) begin
        if (i < 3 && cfg_index == CFG_UPPER_BASE + 3'(i)) begin
          upper_limit[i] <= cfg_data;
        end
        if (i < 3 && cfg_index == CFG_LOWER_BASE + 3'(i)) begin
          lower_limit[i] <= cfg_data;
        end
      end
    end

    spg_axis u_axis (
      .clk   (clk),
      .rst   (rst),
      .en    (fire),
      .cmd   (cmd),
      .upper (upper_limit[i]),
      .lower (lower_limit[i]),
      .stat  (stat[i])
    );
  end

  for (genvar i = 0; i < MASK_AXES; i++) begin : g_mask
    if (i < AXES) begin : g_used
      assign step_m[i]  = stat[i].step;
      assign dir_m[i]   = stat[i].dir;
      assign done_m[i]  = stat[i].done;
      assign below_m[i] = stat[i].below;
      assign above_m[i] = stat[i].above;
      assign clo_m[i]   = stat[i].clamp_low;
      assign chi_m[i]   = stat[i].clamp_high;
    end else begin : g_unused
      assign step_m[i]  = 1'b0;
      assign dir_m[i]   = 1'b0;
      assign done_m[i]  = 1'b0;
      assign below_m[i] = 1'b0;
      assign above_m[i] = 1'b0;
      assign clo_m[i]   = 1'b0;
      assign chi_m[i]   = 1'b0;
    end
  end

  always_comb begin
    pos_sel = 32'd0;
    tgt_sel = 32'd0;
    spd_sel = 16'd0;
    for (int i = 0; i < AXES; i++) begin
      pos_sel = pos_sel | ({32{sel[i]}} & stat[i].position);
      tgt_sel = tgt_sel | ({32{sel[i]}} & stat[i].target);
      spd_sel = spd_sel | ({16{sel[i]}} & stat[i].speed);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fire) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (fire) begin
      results.step_pins         <= step_m;
      results.dir_pins          <= dir_m;
      results.done_mask         <= done_m;
      results.below_limit_mask  <= below_m;
      results.above_limit_mask  <= above_m;
      results.clamped_low_mask  <= clo_m;
      results.clamped_high_mask <= chi_m;
      results.axis_position_out <= pos_sel;
      results.axis_target_out   <= tgt_sel;
      results.axis_speed_out    <= spd_sel;
    end
  end

`ifndef NO_ASSERTIONS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> results.valid)
    else $error("Accepted request produced no result.");

  a_ready_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> (in_valid && results.valid && !results.ready))
    else $error("Input refused without a stalled result.");

  a_command_no_flags: assert property (@(posedge clk) disable iff (rst)
    (fire && in_mode != MODE_TICK) |=>
      (results.below_limit_mask == 3'd0 && results.above_limit_mask == 3'd0 &&
       results.clamped_low_mask == 3'd0 && results.clamped_high_mask == 3'd0))
    else $error("Limit flags set on a command request.");

  a_bad_axis_zero: assert property (@(posedge clk) disable iff (rst)
    (fire && int'(in_axis) >= AXES) |=>
      (results.axis_position_out == 32'd0 && results.axis_target_out == 32'd0 &&
       results.axis_speed_out == 16'd0))
    else $error("Unknown axis reported non-zero state.");
`endif

endmodule

>>> test/step_pulse_checker.sv
module step_pulse_checker
  import spg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  spg_item_if         items,
  spg_result_if       results,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [2:0]  step_pins;
    logic [2:0]  dir_pins;
    logic [2:0]  done_mask;
    logic [2:0]  below_mask;
    logic [2:0]  above_mask;
    logic [2:0]  clamp_low_mask;
    logic [2:0]  clamp_high_mask;
    logic [31:0] position;
    logic [31:0] target;
    logic [15:0] speed;
  } step_report_t;

  logic [31:0]          upper_limit [MASK_AXES];
  logic [31:0]          lower_limit [MASK_AXES];
  logic [31:0]          position [MASK_AXES];
  logic [31:0]          target [MASK_AXES];
  logic [15:0]          half_period [MASK_AXES];
  int unsigned          phase_count [MASK_AXES];
  logic [MASK_AXES-1:0] step_level;
  logic [MASK_AXES-1:0] dir_level;
  logic [MASK_AXES-1:0] done_level;
  step_report_t         expected_report_q [$];

  initial mismatches = 0;
  initial outstanding = 0;

  function automatic void clear_axes();
    for (int i = 0; i < MASK_AXES; i++) begin
      upper_limit[i] = '1;
      lower_limit[i] = '0;
      position[i] = ORIGIN_POS;
      target[i] = ORIGIN_POS;
      half_period[i] = SPEED_RESET;
      phase_count[i] = 0;
    end
    step_level = '1;
    dir_level = '1;
    done_level = '0;
  endfunction

  function automatic void advance_axes(output logic [2:0] below, output logic [2:0] above,
                                       output logic [2:0] clamp_low,
                                       output logic [2:0] clamp_high);
    int unsigned sp;
    below = '0;
    above = '0;
    clamp_low = '0;
    clamp_high = '0;
    for (int i = 0; i < MASK_AXES; i++) begin
      if (position[i] < lower_limit[i]) begin
        below[i] = 1'b1;
      end else if (position[i] > upper_limit[i]) begin
        above[i] = 1'b1;
      end
      if (target[i] < lower_limit[i]) begin
        target[i] = lower_limit[i];
        clamp_low[i] = 1'b1;
      end else if (target[i] > upper_limit[i]) begin
        target[i] = upper_limit[i];
        clamp_high[i] = 1'b1;
      end
      dir_level[i] = position[i] > target[i];
    end
    for (int i = 0; i < MASK_AXES; i++) begin
      sp = 32'(half_period[i]);
      if (sp != 0) begin
        if (position[i] != target[i]) begin
          done_level[i] = 1'b0;
          if (phase_count[i] < sp) begin
            step_level[i] = 1'b1;
          end else if (phase_count[i] < 2 * sp) begin
            step_level[i] = 1'b0;
          end else begin
            phase_count[i] = 0;
            position[i] = dir_level[i] ? position[i] - 32'd1 : position[i] + 32'd1;
          end
          phase_count[i] = phase_count[i] + 1;
        end else begin
          done_level[i] = 1'b1;
        end
      end
    end
  endfunction

  function automatic step_report_t predict_report(input logic [2:0] mode, input logic [1:0] axis,
                                                  input logic [31:0] value,
                                                  input logic [15:0] speed);
    step_report_t rep;
    logic         present;
    logic [2:0]   below, above, clamp_low, clamp_high;
    present = axis < MASK_AXES;
    below = '0;
    above = '0;
    clamp_low = '0;
    clamp_high = '0;
    case (mode)
      MODE_TICK: advance_axes(below, above, clamp_low, clamp_high);
      MODE_ABSOLUTE: if (present) target[axis] = value;
      MODE_RELATIVE: if (present) target[axis] = position[axis] + value;
      MODE_SPEED: if (present) half_period[axis] = speed;
      MODE_ORIGIN: begin
        if (present) begin
          position[axis] = ORIGIN_POS;
          target[axis] = ORIGIN_POS;
        end
      end
      MODE_ESTOP: begin
        for (int i = 0; i < MASK_AXES; i++) begin
          half_period[i] = '0;
          target[i] = position[i];
        end
      end
      default: ;
    endcase
    rep.step_pins = step_level;
    rep.dir_pins = dir_level;
    rep.done_mask = done_level;
    rep.below_mask = below;
    rep.above_mask = above;
    rep.clamp_low_mask = clamp_low;
    rep.clamp_high_mask = clamp_high;
    rep.position = present ? position[axis] : '0;
    rep.target = present ? target[axis] : '0;
    rep.speed = present ? half_period[axis] : '0;
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk) begin
    step_report_t want;
    if (rst) begin
      clear_axes();
      expected_report_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (expected_report_q.size() == 0) begin
          report_mismatch("unrequested result, position", results.axis_position_out, '0);
        end else begin
          want = expected_report_q.pop_front();
          compare_field("step_pins", 32'(results.step_pins), 32'(want.step_pins));
          compare_field("dir_pins", 32'(results.dir_pins), 32'(want.dir_pins));
          compare_field("done_mask", 32'(results.done_mask), 32'(want.done_mask));
          compare_field("below_limit_mask", 32'(results.below_limit_mask),
                        32'(want.below_mask));
          compare_field("above_limit_mask", 32'(results.above_limit_mask),
                        32'(want.above_mask));
          compare_field("clamped_low_mask", 32'(results.clamped_low_mask),
                        32'(want.clamp_low_mask));
          compare_field("clamped_high_mask", 32'(results.clamped_high_mask),
                        32'(want.clamp_high_mask));
          compare_field("axis_position_out", results.axis_position_out, want.position);
          compare_field("axis_target_out", results.axis_target_out, want.target);
          compare_field("axis_speed_out", 32'(results.axis_speed_out), 32'(want.speed));
        end
      end
      if (items.valid && items.ready) begin
        expected_report_q.push_back(predict_report(items.mode, items.axis,
                                                   items.move_value[31:0],
                                                   items.speed_value));
      end
      if (cfg_write) begin
        if (cfg_index >= CFG_LOWER_BASE && cfg_index < CFG_LOWER_BASE + MASK_AXES) begin
          lower_limit[2'(cfg_index - CFG_LOWER_BASE)] = cfg_data;
        end else if (cfg_index >= CFG_UPPER_BASE &&
                     cfg_index < CFG_UPPER_BASE + MASK_AXES) begin
          upper_limit[2'(cfg_index - CFG_UPPER_BASE)] = cfg_data;
        end
      end
    end
    outstanding <= expected_report_q.size();
  end

endmodule

>>> test/multi_axis_step_pulse_generator_tb.sv
module multi_axis_step_pulse_generator_tb;
  import spg_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [1:0] AXIS_ABSENT  = 2'd3;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         SEGMENT_REQUESTS = 100;
  localparam int         CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          mismatches;
  int          outstanding;
  int          sender_idle_pct;
  int          receiver_idle_pct;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;

  spg_item_if   item_ch ();
  spg_result_if result_ch ();

  multi_axis_step_pulse_generator #(
    .AXES(MASK_AXES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .items    (item_ch),
    .results  (result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  step_pulse_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .items      (item_ch),
    .results    (result_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver either serves a long hold-off or stalls at random.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        result_ch.ready = 1'b0;
        hold_left--;
      end else begin
        result_ch.ready = $urandom_range(99) >= receiver_idle_pct;
      end
    end
  end

  task automatic offer(input logic [2:0] md, input logic [1:0] ax,
                       input logic signed [32:0] mv, input logic [15:0] sp);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.mode = md;
    item_ch.axis = ax;
    item_ch.move_value = mv;
    item_ch.speed_value = sp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic quiesce();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data = value;
  endtask

  // Mostly ticks and small moves near the origin, so that axes pulse and arrive.
  task automatic offer_random(output bit counted);
    int                 pick;
    int                 off;
    logic [2:0]         md;
    logic [1:0]         ax;
    logic signed [32:0] mv;
    logic [15:0]        sp;
    pick = $urandom_range(99);
    ax = ($urandom_range(19) == 0) ? AXIS_ABSENT : 2'($urandom_range(MASK_AXES - 1));
    off = int'($urandom_range(12)) - 6;
    mv = {1'($urandom_range(1)), 32'($urandom)};
    sp = 16'($urandom);
    md = MODE_TICK;
    if (pick < 55) begin
      md = MODE_TICK;
    end else if (pick < 66) begin
      md = MODE_RELATIVE;
      if ($urandom_range(9) != 0) mv = 33'(off);
    end else if (pick < 73) begin
      md = MODE_ABSOLUTE;
      if ($urandom_range(9) < 7) mv = 33'(ORIGIN_POS) + 33'(off);
    end else if (pick < 84) begin
      md = MODE_SPEED;
      pick = $urandom_range(9);
      if (pick < 8) begin
        sp = 16'($urandom_range(3, 1));
      end else if (pick == 8) begin
        sp = '0;
      end
    end else if (pick < 90) begin
      md = MODE_ORIGIN;
    end else if (pick < 92) begin
      md = MODE_ESTOP;
    end else if (pick < 95) begin
      md = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
    end
    offer(md, ax, mv, sp);
    counted = !(md == MODE_SPARE_A || md == MODE_SPARE_B ||
                (md != MODE_TICK && md != MODE_ESTOP && ax == AXIS_ABSENT));
  endtask

  initial begin
    int          counted_requests;
    bit          counted;
    logic [31:0] up;
    logic [31:0] lo;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_UPPER_BASE;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_TICK;
    item_ch.axis = '0;
    item_ch.move_value = '0;
    item_ch.speed_value = '0;
    sender_idle_pct = 17;
    receiver_idle_pct = 68;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer(MODE_TICK, 2'd0, '0, '0);
    offer(MODE_SPEED, 2'd0, '0, 16'd1);
    offer(MODE_RELATIVE, 2'd0, 33'sd2, '0);
    repeat (4) offer(MODE_TICK, 2'd0, '0, '0);
    offer(MODE_ABSOLUTE, 2'd1, 33'h0_FFFF_FFFF, '0);
    offer(MODE_RELATIVE, 2'd2, 33'h1_8000_0000, '0);
    offer(MODE_SPEED, 2'd1, '0, 16'hFFFF);
    offer(MODE_SPEED, 2'd2, '0, '0);
    offer(MODE_TICK, 2'd2, '0, '0);
    offer(MODE_SPARE_A, 2'd0, 33'h1_FFFF_FFFF, 16'hFFFF);
    offer(MODE_SPARE_B, AXIS_ABSENT, '0, '0);
    offer(MODE_ABSOLUTE, AXIS_ABSENT, 33'sd1234, '0);
    offer(MODE_TICK, AXIS_ABSENT, '0, '0);
    offer(MODE_SPEED, 2'd0, '0, 16'd3);
    repeat (4) offer(MODE_TICK, 2'd0, '0, '0);
    // The shorter period leaves the phase count past its end.
    offer(MODE_SPEED, 2'd0, '0, 16'd1);
    offer(MODE_TICK, 2'd0, '0, '0);
    offer(MODE_ORIGIN, 2'd1, '0, '0);
    offer(MODE_ESTOP, AXIS_ABSENT, '0, '0);
    offer(MODE_TICK, 2'd1, '0, '0);

    for (int seg = 0; seg < 5; seg++) begin
      if (seg == 2) begin
        @(posedge clk);
        sender_idle_pct = 68;
        receiver_idle_pct = 17;
      end else if (seg == 4) begin
        @(posedge clk);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      quiesce();
      for (int ax = 0; ax < MASK_AXES; ax++) begin
        case (seg)
          0: begin
            up = ORIGIN_POS + 32'd8;
            lo = ORIGIN_POS - 32'd8;
          end
          1: begin
            up = '1;
            lo = '0;
          end
          2: begin
            up = (ax == 0) ? 32'd0 : (ax == 1) ? 32'hFFFF_FFFF : 32'd4000;
            lo = (ax == 0) ? 32'd0 : (ax == 1) ? 32'hFFFF_FFFF : 32'd6000;
          end
          3: begin
            up = ORIGIN_POS + 32'($urandom_range(20));
            lo = ORIGIN_POS - 32'($urandom_range(20));
          end
          default: begin
            up = ORIGIN_POS + 32'($urandom_range(4));
            lo = ORIGIN_POS - 32'($urandom_range(4));
          end
        endcase
        write_register(CFG_UPPER_BASE + 3'(ax), up);
        write_register(CFG_LOWER_BASE + 3'(ax), lo);
      end
      @(negedge clk);
      cfg_write = 1'b0;
      if (seg == 4) begin
        @(posedge clk);
        hold_request = 1'b1;
      end
      counted_requests = 0;
      while (counted_requests < SEGMENT_REQUESTS) begin
        offer_random(counted);
        if (counted) begin
          counted_requests++;
          if (seg == 1 && counted_requests == SEGMENT_REQUESTS / 2) quiesce();
        end
      end
    end

    quiesce();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
src/spg_pkg.sv
src/spg_if.sv
src/spg_axis.sv
src/multi_axis_step_pulse_generator.sv
test/step_pulse_checker.sv
test/multi_axis_step_pulse_generator_tb.sv
